>>> hw/rtl/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
`default_nettype none

package wsd_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
    localparam logic [7:0] HDR_OP_MASK  = 8'h0f;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    typedef logic [LENGTH_BITS-1:0] t_wsd_len;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_wsd_phase;

    typedef enum logic [1:0] {
        ACT_TEXT  = 2'd0,
        ACT_PONG  = 2'd1,
        ACT_CLOSE = 2'd2
    } t_wsd_action;

    typedef struct packed {
        t_wsd_action action;
        logic [3:0]  opcode;
        logic        fin;
        logic        byte_valid;
        logic [7:0]  data;
        logic [7:0]  key;
        logic        last;
    } t_wsd_item;

endpackage

`default_nettype wire

>>> hw/rtl/wsd_front.sv
// header parser and byte classifier of the deframer
`default_nettype none

module wsd_front import wsd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_push,
    output t_wsd_item       o_item
);

    t_wsd_phase  r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_mask_on, n_mask_on;
    t_wsd_len    r_rem, n_rem;
    logic [2:0]  r_hbl, n_hbl;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_pos, n_pos;
    logic        r_closed, n_closed;

    logic [6:0]  w_len7;
    t_wsd_len    w_ext_rem;
    t_wsd_len    w_pay_rem;
    logic        w_pay_last;
    t_wsd_len    w_hd_rem;
    logic        w_hdr_end;
    logic        w_hd_zero;
    logic        w_step;
    logic [7:0]  w_key_byte;

    assign w_step     = i_fire && !r_closed;
    assign w_len7     = i_byte[6:0] & HDR_LEN_MASK[6:0];
    assign w_key_byte = r_key[{~r_pos, 3'b000} +: 8];

    always_comb begin
        w_ext_rem = (|r_rem[LENGTH_BITS-1:LENGTH_BITS-8]) ? '1
                                                          : {r_rem[LENGTH_BITS-9:0], i_byte};
        w_pay_rem  = (r_rem != '0) ? r_rem - t_wsd_len'(1) : r_rem;
        w_pay_last = (w_pay_rem == '0);
        unique case (r_phase)
            PH_HDR1: begin
                w_hd_rem  = {{(LENGTH_BITS-7){1'b0}}, w_len7};
                w_hdr_end = (w_len7 != LEN_EXT16) && (w_len7 != LEN_EXT64) &&
                            ((i_byte & HDR_TOP_BIT) == 8'h00);
            end
            PH_EXTLEN: begin
                w_hd_rem  = w_ext_rem;
                w_hdr_end = (r_hbl == 3'd0) && !r_mask_on;
            end
            PH_MASK: begin
                w_hd_rem  = r_rem;
                w_hdr_end = (r_hbl == 3'd0);
            end
            default: begin
                w_hd_rem  = r_rem;
                w_hdr_end = 1'b0;
            end
        endcase
        w_hd_zero = (w_hd_rem == '0);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (w_step) begin
            unique case (r_phase)
                PH_HDR0: n_phase = PH_HDR1;
                PH_HDR1: begin
                    priority if (w_len7 == LEN_EXT16 || w_len7 == LEN_EXT64) n_phase = PH_EXTLEN;
                    else if (!w_hdr_end)  n_phase = PH_MASK;
                    else if (!w_hd_zero)  n_phase = PH_PAYLOAD;
                    else                  n_phase = PH_HDR0;
                end
                PH_EXTLEN: begin
                    priority if (r_hbl != 3'd0) n_phase = PH_EXTLEN;
                    else if (r_mask_on)         n_phase = PH_MASK;
                    else if (!w_hd_zero)        n_phase = PH_PAYLOAD;
                    else                        n_phase = PH_HDR0;
                end
                PH_MASK: begin
                    priority if (r_hbl != 3'd0) n_phase = PH_MASK;
                    else if (!w_hd_zero)        n_phase = PH_PAYLOAD;
                    else                        n_phase = PH_HDR0;
                end
                PH_PAYLOAD: n_phase = w_pay_last ? PH_HDR0 : PH_PAYLOAD;
                default:    n_phase = PH_HDR0;
            endcase
        end
    end

    // register updates and queue push
    always_comb begin
        n_opcode  = r_opcode;
        n_fin     = r_fin;
        n_mask_on = r_mask_on;
        n_rem     = r_rem;
        n_hbl     = r_hbl;
        n_key     = r_key;
        n_pos     = r_pos;
        n_closed  = r_closed;
        o_push    = 1'b0;
        o_item    = '0;
        o_item.opcode = r_opcode;
        o_item.fin    = r_fin;
        o_item.last   = 1'b1;
        if (w_step) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin    = (i_byte & HDR_TOP_BIT) != 8'h00;
                    n_opcode = 4'(i_byte & HDR_OP_MASK);
                end
                PH_HDR1: begin
                    n_mask_on = (i_byte & HDR_TOP_BIT) != 8'h00;
                    n_key     = '0;
                    n_rem     = '0;
                    priority if (w_len7 == LEN_EXT16) n_hbl = 3'd1;
                    else if (w_len7 == LEN_EXT64)     n_hbl = 3'd7;
                    else begin
                        n_rem = w_hd_rem;
                        if (!w_hdr_end) n_hbl = 3'd3;
                    end
                end
                PH_EXTLEN: begin
                    n_rem = w_ext_rem;
                    priority if (r_hbl != 3'd0) n_hbl = r_hbl - 3'd1;
                    else if (r_mask_on)         n_hbl = 3'd3;
                    else                        n_hbl = r_hbl;
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_hbl != 3'd0) n_hbl = r_hbl - 3'd1;
                end
                PH_PAYLOAD: begin
                    n_pos = r_pos + 2'd1;
                    n_rem = w_pay_rem;
                    unique case (r_opcode)
                        OP_TEXT, OP_PING: begin
                            o_push            = 1'b1;
                            o_item.action     = (r_opcode == OP_TEXT) ? ACT_TEXT : ACT_PONG;
                            o_item.byte_valid = 1'b1;
                            o_item.data       = i_byte;
                            o_item.key        = w_key_byte;
                            o_item.last       = w_pay_last;
                        end
                        OP_CLOSE: begin
                            if (w_pay_last) begin
                                o_push        = 1'b1;
                                o_item.action = ACT_CLOSE;
                                n_closed      = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // header complete
            if (w_hdr_end) begin
                n_pos = 2'd0;
                if (w_hd_zero) begin
                    unique case (r_opcode)
                        OP_TEXT: begin
                            o_push        = 1'b1;
                            o_item.action = ACT_TEXT;
                        end
                        OP_PING: begin
                            o_push        = 1'b1;
                            o_item.action = ACT_PONG;
                        end
                        OP_CLOSE: begin
                            o_push        = 1'b1;
                            o_item.action = ACT_CLOSE;
                            n_closed      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_opcode  <= '0;
            r_fin     <= 1'b0;
            r_mask_on <= 1'b0;
            r_rem     <= '0;
            r_hbl     <= '0;
            r_key     <= '0;
            r_pos     <= '0;
            r_closed  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_fin     <= n_fin;
            r_mask_on <= n_mask_on;
            r_rem     <= n_rem;
            r_hbl     <= n_hbl;
            r_key     <= n_key;
            r_pos     <= n_pos;
            r_closed  <= n_closed;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wsd_queue.sv
// short result queue between parser and output stage
`default_nettype none

module wsd_queue import wsd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_wsd_item i_item,
    input  wire logic      i_pop,
    output logic           o_valid,
    output logic           o_full,
    output t_wsd_item      o_item
);

    t_wsd_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        priority if (w_wr && !w_rd) n_count = r_count + (QUEUE_AW+1)'(1);
        else if (w_rd && !w_wr)     n_count = r_count - (QUEUE_AW+1)'(1);
        else                        n_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wsd_back.sv
// unmasking and output register of the deframer
`default_nettype none

module wsd_back import wsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_wsd_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,
    output logic [2:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    logic        r_valid, n_valid;
    t_wsd_action r_action;
    logic [3:0]  r_opcode;
    logic        r_fin;
    logic        r_bvalid;
    logic [7:0]  r_data;
    logic        r_last;

    assign o_q_pop = i_q_valid && (!r_valid || i_m_axis_tready);

    always_comb begin
        n_valid = r_valid;
        priority if (o_q_pop)       n_valid = 1'b1;
        else if (i_m_axis_tready)   n_valid = 1'b0;
        else                        n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_action <= i_q_item.action;
            r_opcode <= i_q_item.opcode;
            r_fin    <= i_q_item.fin;
            r_bvalid <= i_q_item.byte_valid;
            r_data   <= i_q_item.data ^ i_q_item.key;
            r_last   <= i_q_item.last;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {3'b000, r_data, r_fin, r_opcode};
    assign o_m_axis_tuser  = {r_bvalid, r_action};
    assign o_m_axis_tlast  = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/websocket_frame_deframer.sv
// top level of the websocket receive frame deframer
//
// Takes one received stream byte per beat and parses websocket frame headers (fin, opcode,
// mask bit, 7, 16 or 64 bit length, mask key), unmasks payload bytes and emits text bytes,
// ping bytes to be echoed, empty-frame markers and one close marker per close frame; after
// a close every byte is swallowed until reset. A byte is accepted every cycle while the
// two-entry result queue has room; its result is written into the queue and then moved
// into the output register, from which the master side takes it, and results leave at
// one per cycle while the master side is ready. Ready drops only when the master side
// stalls long enough for the queue to fill.
`default_nettype none

module websocket_frame_deframer import wsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] data_byte
    input  wire logic [7:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [3:0] frame_opcode, [4] final_flag, [12:5] payload_byte, [15:13] zero
    output logic [15:0]      o_m_axis_tdata,
    // [1:0] action, [2] byte_valid
    output logic [2:0]       o_m_axis_tuser,
    // last_in_frame
    output logic             o_m_axis_tlast
);

    logic      w_fire;
    logic      w_push;
    t_wsd_item w_push_item;
    logic      w_q_valid;
    logic      w_q_full;
    t_wsd_item w_q_item;
    logic      w_q_pop;

    assign o_s_axis_tready = !w_q_full;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;

    wsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (i_s_axis_tdata),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_empty_has_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[2] |-> o_m_axis_tdata[12:5] == 8'h00)
        else $error("result without payload byte carries nonzero data");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == ACT_CLOSE |-> o_m_axis_tlast)
        else $error("close result not marked last");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("queued result not moved to the output register");
`endif

endmodule

`default_nettype wire
